>>> rtl/assert_macros.svh
// Assertion helpers used by diffusion_tensor_2x2.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dts assertion failed");

// Next-cycle implication, checked out of reset.
`define DTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dts assertion failed");

`endif

>>> rtl/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Types and fixed constants of the diffusion tensor block.
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam int Q_W         = 33;   // quotient of floor(n*2^32/d), n <= d
    localparam int VAL_W       = 34;   // quotient padded to an even width
    localparam int ROOT_W      = 17;   // isqrt of a 33-bit value
    localparam int SREM_W      = 19;   // isqrt remainder, at most 2*root
    localparam int OUT_W       = 17;
    localparam int HX_W        = 18;
    localparam int CNT_W       = 6;
    localparam int DIV_STEPS   = 33;
    localparam int SQRT_STEPS  = 17;
    localparam logic [HX_W-1:0] ONE_Q16 = 18'h10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQU,
        ST_SQB,
        ST_SUMR,
        ST_DIV,
        ST_SQRT,
        ST_MX,
        ST_MY,
        ST_MS,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        JOB_M,
        JOB_R,
        JOB_S
    } job_t;

endpackage

>>> rtl/dts_sub.sv
// ----------------------------------------------------------------------------
// dts_sub
// Shared compare/subtract unit used by the divider and square root steps.
// ----------------------------------------------------------------------------
module dts_sub #(
    parameter int W = 22
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         ge
);

    logic borrow;

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge = !borrow;

endmodule

>>> rtl/dts_mul.sv
// ----------------------------------------------------------------------------
// dts_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module dts_mul #(
    parameter int W = 21
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p_reg
);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

endmodule

>>> rtl/diffusion_tensor_2x2.sv
// A beat without window_last is added to the sums and the block stays ready for the next beat.
// A window_last beat starts the evaluation: three 33-step divisions and three 17-step
// square roots on one shared subtractor, plus the states PREP to SUMR and MX to DONE.
// When the eigenvector falls back to (1,0) only one division and root run.
// No beat is accepted while a window is evaluated; the output register frees the input side.
// Reset (aresetn low, synchronous): sums clear, sequencer idles, no result pending.
// ----------------------------------------------------------------------------
// diffusion_tensor_2x2
// Structure tensor accumulation and diffusion tensor evaluation for one window
// at a time (one set of sums for all channels), on a shared subtract unit and a shared multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module diffusion_tensor_2x2
    import dts_pkg::*;
#(
    parameter int PIXEL_BITS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [PIXEL_BITS-1:0]   s_left_pixel,
    input  logic [PIXEL_BITS-1:0]   s_right_pixel,
    input  logic [PIXEL_BITS-1:0]   s_up_pixel,
    input  logic [PIXEL_BITS-1:0]   s_down_pixel,
    input  logic [1:0]              s_channel,
    input  logic                    s_window_last,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_channel_out,
    output logic [OUT_W-1:0]        m_tensor_xx,
    output logic signed [OUT_W-1:0] m_tensor_xy,
    output logic [OUT_W-1:0]        m_tensor_yy
);

    localparam int SQ_W = 2 * PIXEL_BITS + 4;
    localparam int XY_W = 2 * PIXEL_BITS + 5;
    localparam int MW   = XY_W;
    localparam int PW   = 2 * MW;
    localparam int RW   = 2 * XY_W + 1;
    localparam int DW   = RW + 1;
    localparam int TR_W = SQ_W + 2;
    localparam int PP_W = 2 * PIXEL_BITS + 2;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    logic [SQ_W-1:0]   gxx_reg, gxx_next, gyy_reg, gyy_next;
    logic [XY_W-1:0]   gxy_reg, gxy_next;
    logic [SQ_W-1:0]   a_reg, a_next, d_reg, d_next;
    logic [XY_W-1:0]   b_reg, b_next;
    logic [SQ_W-1:0]   uabs_reg, uabs_next;
    logic [XY_W-1:0]   babs_reg, babs_next;
    logic              bneg_reg, bneg_next, ge_reg, ge_next, spec_reg, spec_next;
    logic [TR_W-1:0]   tr_reg, tr_next;
    logic [PW-1:0]     usq_reg, usq_next, bsq_reg, bsq_next;
    logic [RW-1:0]     r2_reg, r2_next;
    logic [DW-1:0]     rem_reg, rem_next, dd_reg, dd_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [ROOT_W-1:0] root_reg, root_next_step, root_next;
    logic [SREM_W-1:0] srem_reg, srem_next;
    logic [ROOT_W-1:0] mq_reg, mq_next, r_reg, r_next, s_reg, s_next;
    logic [OUT_W-1:0]  xx_reg, xx_next, xy_reg, xy_next, yy_reg, yy_next;
    logic [1:0]        chan_reg, chan_next;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_chan_reg, m_chan_next;
    logic [OUT_W-1:0]  m_xx_reg, m_xx_next, m_xy_reg, m_xy_next, m_yy_reg, m_yy_next;

    // gradient products
    logic signed [PIXEL_BITS:0] dx, dy;
    logic signed [PP_W-1:0]     pxx, pxy, pyy;

    // shared units
    logic [DW-1:0]     sub_a, sub_b, sub_diff, div_cand;
    logic              sub_ge;
    logic [SREM_W+1:0] sq_cand;
    logic [SREM_W-1:0] trial;
    logic              mul_en;
    logic [MW-1:0]     mul_a, mul_b;
    logic [PW-1:0]     p_reg;
    logic [HX_W-1:0]   hx, hy;
    logic [OUT_W-1:0]  smag;
    logic              accept;

    assign dx  = $signed({1'b0, s_right_pixel}) - $signed({1'b0, s_left_pixel});
    assign dy  = $signed({1'b0, s_down_pixel}) - $signed({1'b0, s_up_pixel});
    assign pxx = dx * dx;
    assign pxy = dx * dy;
    assign pyy = dy * dy;

    assign div_cand = (cnt_reg == '0) ? rem_reg : {rem_reg[DW-2:0], 1'b0};
    assign sq_cand  = {srem_reg, val_reg[VAL_W-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign sub_a    = (state_reg == ST_SQRT) ? DW'(sq_cand) : div_cand;
    assign sub_b    = (state_reg == ST_SQRT) ? DW'(trial) : dd_reg;
    assign root_next_step = {root_reg[ROOT_W-2:0], sub_ge};

    assign hx   = ge_reg ? (ONE_Q16 - HX_W'(r_reg)) : (ONE_Q16 + HX_W'(r_reg));
    assign hy   = ge_reg ? (ONE_Q16 + HX_W'(r_reg)) : (ONE_Q16 - HX_W'(r_reg));
    assign smag = p_reg[16 +: OUT_W];

    dts_sub #(.W(DW)) u_sub (
        .a    (sub_a),
        .b    (sub_b),
        .diff (sub_diff),
        .ge   (sub_ge)
    );

    dts_mul #(.W(MW)) u_mul (
        .aclk  (aclk),
        .en    (mul_en),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (p_reg)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gxx_reg     <= '0;
            gxy_reg     <= '0;
            gyy_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gxx_reg     <= gxx_next;
            gxy_reg     <= gxy_next;
            gyy_reg     <= gyy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg  <= job_next;
        a_reg    <= a_next;
        d_reg    <= d_next;
        b_reg    <= b_next;
        uabs_reg <= uabs_next;
        babs_reg <= babs_next;
        bneg_reg <= bneg_next;
        ge_reg   <= ge_next;
        spec_reg <= spec_next;
        tr_reg   <= tr_next;
        usq_reg  <= usq_next;
        bsq_reg  <= bsq_next;
        r2_reg   <= r2_next;
        rem_reg  <= rem_next;
        dd_reg   <= dd_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        val_reg  <= val_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
        mq_reg   <= mq_next;
        r_reg    <= r_next;
        s_reg    <= s_next;
        xx_reg   <= xx_next;
        xy_reg   <= xy_next;
        yy_reg   <= yy_next;
        chan_reg <= chan_next;
        m_chan_reg <= m_chan_next;
        m_xx_reg   <= m_xx_next;
        m_xy_reg   <= m_xy_next;
        m_yy_reg   <= m_yy_next;
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        gxx_next   = gxx_reg;
        gxy_next   = gxy_reg;
        gyy_next   = gyy_reg;
        a_next     = a_reg;
        d_next     = d_reg;
        b_next     = b_reg;
        uabs_next  = uabs_reg;
        babs_next  = babs_reg;
        bneg_next  = bneg_reg;
        ge_next    = ge_reg;
        spec_next  = spec_reg;
        tr_next    = tr_reg;
        usq_next   = usq_reg;
        bsq_next   = bsq_reg;
        r2_next    = r2_reg;
        rem_next   = rem_reg;
        dd_next    = dd_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        mq_next    = mq_reg;
        r_next     = r_reg;
        s_next     = s_reg;
        xx_next    = xx_reg;
        xy_next    = xy_reg;
        yy_next    = yy_reg;
        chan_next  = chan_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        m_valid_next = m_valid_reg && !m_ready;
        m_chan_next  = m_chan_reg;
        m_xx_next    = m_xx_reg;
        m_xy_next    = m_xy_reg;
        m_yy_next    = m_yy_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    gxx_next = gxx_reg + SQ_W'(pxx);
                    gxy_next = gxy_reg + XY_W'(pxy);
                    gyy_next = gyy_reg + SQ_W'(pyy);
                    if (s_window_last) begin
                        a_next     = gxx_next;
                        b_next     = gxy_next;
                        d_next     = gyy_next;
                        chan_next  = s_channel;
                        gxx_next   = '0;
                        gxy_next   = '0;
                        gyy_next   = '0;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                ge_next    = (a_reg >= d_reg);
                uabs_next  = ge_next ? (a_reg - d_reg) : (d_reg - a_reg);
                bneg_next  = b_reg[XY_W-1];
                // two's complement magnitude; the most negative code maps to itself
                babs_next  = bneg_next ? (XY_W'(0) - b_reg) : b_reg;
                spec_next  = (babs_next == '0) && (a_reg <= d_reg);
                tr_next    = TR_W'(a_reg) + TR_W'(d_reg) + TR_W'(4);
                state_next = ST_SQU;
            end
            ST_SQU: begin
                mul_en     = 1'b1;
                mul_a      = MW'(uabs_reg);
                mul_b      = MW'(uabs_reg);
                state_next = ST_SQB;
            end
            ST_SQB: begin
                usq_next   = p_reg;
                mul_en     = 1'b1;
                mul_a      = babs_reg;
                mul_b      = babs_reg;
                state_next = ST_SUMR;
            end
            ST_SUMR: begin
                bsq_next   = p_reg;
                r2_next    = RW'(usq_reg) + (RW'(p_reg) << 2);
                // first job: 1/sqrt(1 + trace/4), with trace = a + d
                job_next   = JOB_M;
                rem_next   = DW'(4);
                dd_next    = DW'(tr_reg);
                q_next     = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = sub_ge ? sub_diff : div_cand;
                q_next   = {q_reg[Q_W-2:0], sub_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    val_next   = {1'b0, q_next};
                    root_next  = '0;
                    srem_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                srem_next = sub_ge ? sub_diff[SREM_W-1:0] : sq_cand[SREM_W-1:0];
                root_next = root_next_step;
                val_next  = {val_reg[VAL_W-3:0], 2'b00};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    cnt_next = '0;
                    q_next   = '0;
                    case (job_reg)
                        JOB_M: begin
                            mq_next = root_next_step;
                            if (spec_reg) begin
                                // eigenvector falls back to (1,0)
                                xx_next    = root_next_step;
                                xy_next    = '0;
                                yy_next    = '0;
                                state_next = ST_DONE;
                            end else begin
                                job_next   = JOB_R;
                                rem_next   = DW'(usq_reg);
                                dd_next    = DW'(r2_reg);
                                state_next = ST_DIV;
                            end
                        end
                        JOB_R: begin
                            r_next     = root_next_step;
                            job_next   = JOB_S;
                            rem_next   = DW'(bsq_reg);
                            dd_next    = DW'(r2_reg);
                            state_next = ST_DIV;
                        end
                        default: begin
                            s_next     = root_next_step;
                            state_next = ST_MX;
                        end
                    endcase
                end
            end
            ST_MX: begin
                mul_en     = 1'b1;
                mul_a      = MW'(mq_reg);
                mul_b      = MW'(hx);
                state_next = ST_MY;
            end
            ST_MY: begin
                xx_next    = p_reg[17 +: OUT_W];
                mul_en     = 1'b1;
                mul_a      = MW'(mq_reg);
                mul_b      = MW'(hy);
                state_next = ST_MS;
            end
            ST_MS: begin
                yy_next    = p_reg[17 +: OUT_W];
                mul_en     = 1'b1;
                mul_a      = MW'(mq_reg);
                mul_b      = MW'(s_reg);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                xy_next    = bneg_reg ? smag : (OUT_W'(0) - smag);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_chan_next  = chan_reg;
                    m_xx_next    = xx_reg;
                    m_xy_next    = xy_reg;
                    m_yy_next    = yy_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_chan_reg;
    assign m_tensor_xx   = m_xx_reg;
    assign m_tensor_xy   = m_xy_reg;
    assign m_tensor_yy   = m_yy_reg;

    `DTS_ASSERT_IMP(a_div_count, state_reg == ST_DIV, cnt_reg < CNT_W'(DIV_STEPS))
    `DTS_ASSERT_NXT(a_sums_cleared, accept && s_window_last, {gxx_reg, gxy_reg, gyy_reg} == '0)
    `DTS_ASSERT_IMP(a_sqrt_rem, state_reg == ST_SQRT, srem_reg <= SREM_W'({root_reg, 1'b0}))
    `DTS_ASSERT_IMP(a_out_from_done, $rose(m_valid_reg), $past(state_reg == ST_DONE))

endmodule
